// ----- hw/rtl/aesd_pkg.sv -----
// Shared constants, types and GF(2^8) helpers for the AES-128 ECB decrypt block.
package aesd_pkg;

   localparam int NUM_ROUNDS_DEF = 10;
   localparam int BLOCK_W = 64;
   localparam int KEY_W = 32;
   localparam int IDX_W = 6;

   localparam logic REQ_KEY_WRITE = 1'b0;
   localparam logic REQ_DECRYPT = 1'b1;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] state_type;

   function automatic byte_type xtime(input byte_type a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic byte_type gf_mul(input byte_type a, input byte_type b);
      byte_type acc;
      byte_type p;
      acc = 8'h00;
      p = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) acc = acc ^ p;
         p = xtime(p);
      end
      gf_mul = acc;
   endfunction

   // Full multiply for table build only (elaboration-time constant folding).
   function automatic byte_type gf_mul8(input byte_type a, input byte_type b);
      byte_type acc;
      byte_type p;
      acc = 8'h00;
      p = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ p;
         p = xtime(p);
      end
      gf_mul8 = acc;
   endfunction

   function automatic byte_type gf_inv(input byte_type a);
      byte_type p;
      byte_type r;
      p = a;
      r = 8'h01;
      for (int i = 1; i < 8; i++) begin
         p = gf_mul8(p, p);
         r = gf_mul8(r, p);
      end
      gf_inv = r;
   endfunction

   function automatic byte_type inv_sbox_calc(input byte_type y);
      byte_type t;
      t = {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]} ^ 8'h05;
      inv_sbox_calc = gf_inv(t);
   endfunction

   typedef byte_type sbox_table_type [256];

   function automatic sbox_table_type build_inv_sbox();
      sbox_table_type tab;
      for (int i = 0; i < 256; i++) tab[i] = inv_sbox_calc(byte_type'(i));
      build_inv_sbox = tab;
   endfunction

   localparam sbox_table_type INV_SBOX = build_inv_sbox();

   // InvShiftRows then InvSubBytes; byte index 4*c + r.
   function automatic state_type inv_shift_sub(input state_type s);
      state_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] =
               INV_SBOX[s[127 - 8 * (4 * c + r) -: 8]];
         end
      end
      inv_shift_sub = t;
   endfunction

   function automatic state_type inv_mix(input state_type s);
      state_type t;
      byte_type a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         t[127 - 32 * c -: 8] = gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b)
                                ^ gf_mul(a2, 8'h0d) ^ gf_mul(a3, 8'h09);
         t[119 - 32 * c -: 8] = gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0e)
                                ^ gf_mul(a2, 8'h0b) ^ gf_mul(a3, 8'h0d);
         t[111 - 32 * c -: 8] = gf_mul(a0, 8'h0d) ^ gf_mul(a1, 8'h09)
                                ^ gf_mul(a2, 8'h0e) ^ gf_mul(a3, 8'h0b);
         t[103 - 32 * c -: 8] = gf_mul(a0, 8'h0b) ^ gf_mul(a1, 8'h0d)
                                ^ gf_mul(a2, 8'h09) ^ gf_mul(a3, 8'h0e);
      end
      inv_mix = t;
   endfunction

endpackage

// ----- hw/rtl/aesd_req_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface aesd_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [5:0]  req_key_index;
   logic [31:0] req_key_word;
   logic [63:0] req_block_hi;
   logic [63:0] req_block_lo;
   modport source (output valid, req_type, req_key_index, req_key_word, req_block_hi,
                   req_block_lo, input ready);
   modport sink (input valid, req_type, req_key_index, req_key_word, req_block_hi,
                 req_block_lo, output ready);
endinterface

interface aesd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] rsp_plain_hi;
   logic [63:0] rsp_plain_lo;
   modport source (output valid, rsp_plain_hi, rsp_plain_lo, input ready);
   modport sink (input valid, rsp_plain_hi, rsp_plain_lo, output ready);
endinterface

// ----- hw/rtl/aes128_ecb_block_decrypt.sv -----
// Top level: pipelined AES inverse cipher with a software-loaded key schedule.
// One block word enters per cycle when the output side keeps up. A decrypt block
// runs through NUM_ROUNDS register stages (10 for AES-128). Stage 0 applies the
// initial AddRoundKey, and each further stage does one inverse round with
// InvMixColumns. The final round, without InvMixColumns, feeds the output
// register. The whole pipe advances only when the output register is free or
// being drained, so a stall holds every stage. Round keys are read from
// flip-flops by every stage. A key write therefore waits, with ready low, until
// no block is left in the pipe or the output register; it is then taken and
// gives no response. A block that follows a key write sees the new word.
module aes128_ecb_block_decrypt
   import aesd_pkg::*;
#(
   parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
   input logic clock,
   input logic reset,
   aesd_req_if.sink req,
   aesd_rsp_if.source rsp
);

   localparam int KEY_WORDS = 4 * (NUM_ROUNDS + 1);
   localparam int STAGES = NUM_ROUNDS;

   logic [31:0] key_ff [KEY_WORDS];
   state_type   st_ff [STAGES];
   logic        vld_ff [STAGES];
   state_type   out_ff;
   logic        out_vld_ff;
   logic        advance;
   logic        pipe_busy;
   state_type   st_in [STAGES];
   state_type   out_in;

   function automatic state_type rkey(input int rnd, input logic [31:0] k [KEY_WORDS]);
      rkey = {k[4 * rnd], k[4 * rnd + 1], k[4 * rnd + 2], k[4 * rnd + 3]};
   endfunction

   always_comb begin
      pipe_busy = out_vld_ff;
      for (int i = 0; i < STAGES; i++) pipe_busy = pipe_busy | vld_ff[i];
   end

   assign advance = !out_vld_ff || rsp.ready;
   // Hold a key write until no block in flight can see the store change.
   assign req.ready = advance && (req.req_type == REQ_DECRYPT || !pipe_busy);
   assign rsp.valid = out_vld_ff;
   assign rsp.rsp_plain_hi = out_ff[127:64];
   assign rsp.rsp_plain_lo = out_ff[63:0];

   always_comb begin
      st_in[0] = {req.req_block_hi, req.req_block_lo} ^ rkey(NUM_ROUNDS, key_ff);
      for (int i = 1; i < STAGES; i++) begin
         st_in[i] = inv_mix(inv_shift_sub(st_ff[i - 1]) ^ rkey(NUM_ROUNDS - i, key_ff));
      end
      out_in = inv_shift_sub(st_ff[STAGES - 1]) ^ rkey(0, key_ff);
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.req_type == REQ_KEY_WRITE
          && int'(req.req_key_index) < KEY_WORDS) begin
         key_ff[req.req_key_index] <= req.req_key_word;
      end
      if (advance) begin
         for (int i = 0; i < STAGES; i++) st_ff[i] <= st_in[i];
         out_ff <= out_in;
      end
      if (reset) begin
         for (int i = 0; i < STAGES; i++) vld_ff[i] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req.valid && req.ready && req.req_type == REQ_DECRYPT;
         for (int i = 1; i < STAGES; i++) vld_ff[i] <= vld_ff[i - 1];
         out_vld_ff <= vld_ff[STAGES - 1];
      end
   end

endmodule
